>>> sv/ttb_pkg.sv
// Shared constants, types and controller/datapath bundles for the triangle
// tangent basis unit. No dependencies.
package ttb_pkg;

	localparam int INDEX_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int COORD_W   = 32;          // Q16.16 coordinate
	localparam int DIFF_W    = COORD_W + 1; // edge or texture delta
	localparam int PROD_W    = 2 * COORD_W; // product magnitude
	localparam int MAG_W     = PROD_W + 1;  // magnitude of a difference of products
	localparam int ACC_W     = MAG_W + 1;   // signed difference of products
	localparam int MUL_STEPS = 14;          // 2 for det, 2 for each of 6 numerators
	localparam int STEP_W    = $clog2(MUL_STEPS);
	localparam int DIV_STEPS = COORD_W;     // quotient bits per divide
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int LANES     = 6;           // tangent and binormal, x y z
	localparam int ACC_N     = LANES + 1;   // determinant plus numerators

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	typedef struct packed {
		logic              in_ready;
		logic              load_first;
		logic              load_second;
		logic              load_third;
		logic              diff_en;
		logic              mul_en;
		logic [STEP_W-1:0] mul_sel;
		logic              prep_en;
		logic              div_en;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic det_zero;
		logic out_full;
	} stat_t;

endpackage

>>> sv/ttb_if.sv
// Handshake channels of the triangle tangent basis unit: corner in, basis out.
// Depends on ttb_pkg.
interface ttb_in_if #(parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEF);
	import ttb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] vertex_index;
	coord_t                pos_x;
	coord_t                pos_y;
	coord_t                pos_z;
	coord_t                tex_u;
	coord_t                tex_v;

	modport source(output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
		input ready);
	modport sink(input valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
		output ready);
endinterface

interface ttb_out_if #(parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEF);
	import ttb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] corner_index;
	coord_t                tangent_x;
	coord_t                tangent_y;
	coord_t                tangent_z;
	coord_t                binormal_x;
	coord_t                binormal_y;
	coord_t                binormal_z;
	logic                  degenerate;
	logic                  clipped;

	modport source(output valid, corner_index, tangent_x, tangent_y, tangent_z,
		binormal_x, binormal_y, binormal_z, degenerate, clipped, input ready);
	modport sink(input valid, corner_index, tangent_x, tangent_y, tangent_z,
		binormal_x, binormal_y, binormal_z, degenerate, clipped, output ready);
endinterface

>>> sv/ttb_ctrl.sv
// Sequencer of the triangle tangent basis unit: corner count, multiply and
// divide step counters. Depends on ttb_pkg.
module ttb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  ttb_pkg::stat_t stat,
	output ttb_pkg::cmd_t  cmd
);
	import ttb_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIFF  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_PREP  = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]           state_q;
	logic [1:0]           count_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 take;

	always_comb begin
		cmd             = '0;
		cmd.in_ready    = (state_q == S_IDLE);
		take            = cmd.in_ready && stat.in_valid;
		cmd.load_first  = take && (count_q != 2'd1) && (count_q != 2'd2);
		cmd.load_second = take && (count_q == 2'd1);
		cmd.load_third  = take && (count_q == 2'd2);
		cmd.diff_en     = (state_q == S_DIFF);
		cmd.mul_en      = (state_q == S_MUL);
		cmd.mul_sel     = step_q;
		cmd.prep_en     = (state_q == S_PREP);
		cmd.div_en      = (state_q == S_DIV);
		cmd.out_load    = (state_q == S_FIN) && !stat.out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= 2'd0;
			step_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.load_first)  count_q <= 2'd1;
			if (cmd.load_second) count_q <= 2'd2;
			if (cmd.load_third)  count_q <= 2'd0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_third) state_q <= S_DIFF;
				end
				S_DIFF: begin
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(MUL_STEPS - 1)) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_PREP;
				S_PREP: begin
					div_cnt_q <= '0;
					state_q   <= stat.det_zero ? S_FIN : S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_q <= S_FIN;
				end
				S_FIN: begin
					if (!stat.out_full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/ttb_dp.sv
// Datapath of the triangle tangent basis unit: corner registers, deltas, one
// shared 32x32 multiplier with accumulators, six bit-serial dividers, output
// register. Depends on ttb_pkg and ttb_if.
module ttb_dp #(
	parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEF,
	parameter int FRAC_BITS  = ttb_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ttb_in_if.sink         corner,
	ttb_out_if.source      basis,
	input  ttb_pkg::cmd_t  cmd,
	output ttb_pkg::stat_t stat
);
	import ttb_pkg::*;

	localparam int NSH_W = MAG_W + FRAC_BITS;
	localparam int HI_W  = NSH_W - COORD_W;

	function automatic logic [COORD_W-1:0] abs_diff(diff_t v);
		logic [DIFF_W-1:0] m;
		m = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
		return m[COORD_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] abs_acc(acc_t v);
		logic [ACC_W-1:0] m;
		m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		return m[MAG_W-1:0];
	endfunction

	logic [INDEX_BITS-1:0] idx0_q;
	coord_t p0_q[3], p1_q[3], p2_q[3];
	coord_t t0_q[2], t1_q[2], t2_q[2];
	diff_t  e1_q[3], e2_q[3];
	diff_t  du1_q, dv1_q, du2_q, dv2_q;

	diff_t             op_a, op_b, ea, eb;
	logic [STEP_W-1:0] k;
	logic [PROD_W-1:0] prod_s1;
	logic              neg_s1, vld_s1;
	logic [STEP_W-1:0] sel_s1;
	acc_t              pext, psg;
	acc_t              acc_q[ACC_N];

	logic [MAG_W-1:0]   dabs, dmag_q;
	logic [MAG_W:0]     rem_q[LANES];
	logic [COORD_W-1:0] lo_q[LANES], quo_q[LANES], res[LANES];
	logic [LANES-1:0]   ovf_q, neg_q, clip;

	coord_t                res_q[LANES];
	logic [INDEX_BITS-1:0] idx_out_q;
	logic                  deg_q, clip_q, out_vld_q;

	assign corner.ready  = cmd.in_ready;
	assign stat.in_valid = corner.valid;
	assign stat.det_zero = (acc_q[0] == '0);
	assign stat.out_full = out_vld_q && !basis.ready;

	// corner capture and deltas
	always_ff @(posedge clk) begin
		if (cmd.load_first) begin
			idx0_q  <= corner.vertex_index;
			p0_q[0] <= corner.pos_x;
			p0_q[1] <= corner.pos_y;
			p0_q[2] <= corner.pos_z;
			t0_q[0] <= corner.tex_u;
			t0_q[1] <= corner.tex_v;
		end
		if (cmd.load_second) begin
			p1_q[0] <= corner.pos_x;
			p1_q[1] <= corner.pos_y;
			p1_q[2] <= corner.pos_z;
			t1_q[0] <= corner.tex_u;
			t1_q[1] <= corner.tex_v;
		end
		if (cmd.load_third) begin
			p2_q[0] <= corner.pos_x;
			p2_q[1] <= corner.pos_y;
			p2_q[2] <= corner.pos_z;
			t2_q[0] <= corner.tex_u;
			t2_q[1] <= corner.tex_v;
		end
		if (cmd.diff_en) begin
			for (int c = 0; c < 3; c++) begin
				e1_q[c] <= DIFF_W'(p1_q[c]) - DIFF_W'(p0_q[c]);
				e2_q[c] <= DIFF_W'(p2_q[c]) - DIFF_W'(p0_q[c]);
			end
			du1_q <= DIFF_W'(t1_q[0]) - DIFF_W'(t0_q[0]);
			dv1_q <= DIFF_W'(t1_q[1]) - DIFF_W'(t0_q[1]);
			du2_q <= DIFF_W'(t2_q[0]) - DIFF_W'(t0_q[0]);
			dv2_q <= DIFF_W'(t2_q[1]) - DIFF_W'(t0_q[1]);
		end
	end

	// operand select: steps 0,1 form det, then four steps per axis
	always_comb begin
		k  = cmd.mul_sel - STEP_W'(2);
		ea = e1_q[0];
		eb = e2_q[0];
		case (k[3:2])
			2'd1: begin
				ea = e1_q[1];
				eb = e2_q[1];
			end
			2'd2: begin
				ea = e1_q[2];
				eb = e2_q[2];
			end
			default: ;
		endcase
		if (cmd.mul_sel == STEP_W'(0)) begin
			op_a = du1_q;
			op_b = dv2_q;
		end else if (cmd.mul_sel == STEP_W'(1)) begin
			op_a = du2_q;
			op_b = dv1_q;
		end else begin
			case (k[1:0])
				2'd0: begin
					op_a = dv2_q;
					op_b = ea;
				end
				2'd1: begin
					op_a = dv1_q;
					op_b = eb;
				end
				2'd2: begin
					op_a = du1_q;
					op_b = eb;
				end
				default: begin
					op_a = du2_q;
					op_b = ea;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= cmd.mul_en;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(abs_diff(op_a)) * PROD_W'(abs_diff(op_b));
		neg_s1  <= op_a[DIFF_W-1] ^ op_b[DIFF_W-1];
		sel_s1  <= cmd.mul_sel;
	end

	always_comb begin
		pext = acc_t'({{(ACC_W-PROD_W){1'b0}}, prod_s1});
		psg  = neg_s1 ? -pext : pext;
	end

	// even step loads the accumulator, odd step subtracts
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (!sel_s1[0]) acc_q[sel_s1[STEP_W-1:1]] <= psg;
			else            acc_q[sel_s1[STEP_W-1:1]] <= acc_q[sel_s1[STEP_W-1:1]] - psg;
		end
	end

	assign dabs = abs_acc(acc_q[0]);

	// restoring dividers, one quotient bit per step after an overflow check
	always_ff @(posedge clk) begin
		logic [NSH_W-1:0] nsh;
		logic [HI_W-1:0]  hi;
		logic [MAG_W:0]   rem2;
		logic             ge;
		if (cmd.prep_en) begin
			dmag_q <= dabs;
			for (int l = 0; l < LANES; l++) begin
				nsh      = {abs_acc(acc_q[l+1]), {FRAC_BITS{1'b0}}};
				hi       = nsh[NSH_W-1:COORD_W];
				ovf_q[l] <= (MAG_W'(hi) >= dabs);
				rem_q[l] <= (MAG_W+1)'(hi);
				lo_q[l]  <= nsh[COORD_W-1:0];
				neg_q[l] <= acc_q[l+1][ACC_W-1] ^ acc_q[0][ACC_W-1];
			end
		end
		if (cmd.div_en) begin
			for (int l = 0; l < LANES; l++) begin
				rem2     = {rem_q[l][MAG_W-1:0], lo_q[l][COORD_W-1]};
				ge       = (rem2 >= {1'b0, dmag_q});
				rem_q[l] <= ge ? rem2 - {1'b0, dmag_q} : rem2;
				quo_q[l] <= {quo_q[l][COORD_W-2:0], ge};
				lo_q[l]  <= {lo_q[l][COORD_W-2:0], 1'b0};
			end
		end
	end

	// saturate to the signed 32-bit range
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (!neg_q[l]) begin
				clip[l] = ovf_q[l] || quo_q[l][COORD_W-1];
				res[l]  = clip[l] ? {1'b0, {(COORD_W-1){1'b1}}} : quo_q[l];
			end else begin
				clip[l] = ovf_q[l] || (quo_q[l] > {1'b1, {(COORD_W-1){1'b0}}});
				res[l]  = clip[l] ? {1'b1, {(COORD_W-1){1'b0}}} : -quo_q[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           out_vld_q <= 1'b0;
		else if (cmd.out_load) out_vld_q <= 1'b1;
		else if (basis.ready)  out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			idx_out_q <= idx0_q;
			deg_q     <= stat.det_zero;
			clip_q    <= !stat.det_zero && (|clip);
			for (int l = 0; l < LANES; l++)
				res_q[l] <= stat.det_zero ? '0 : coord_t'(res[l]);
		end
	end

	assign basis.valid        = out_vld_q;
	assign basis.corner_index = idx_out_q;
	assign basis.tangent_x    = res_q[0];
	assign basis.binormal_x   = res_q[1];
	assign basis.tangent_y    = res_q[2];
	assign basis.binormal_y   = res_q[3];
	assign basis.tangent_z    = res_q[4];
	assign basis.binormal_z   = res_q[5];
	assign basis.degenerate   = deg_q;
	assign basis.clipped      = clip_q;
endmodule

>>> sv/triangle_tangent_basis.sv
// Top level of the per-triangle tangent and binormal unit.
// Depends on ttb_pkg, ttb_if, ttb_ctrl and ttb_dp.
//
//  channel   dir   handshake        payload
//  corner    in    valid / ready    vertex_index, pos_x/y/z, tex_u/v (Q16.16)
//  basis     out   valid / ready    corner_index, tangent_x/y/z, binormal_x/y/z,
//                                   degenerate, clipped
//
// Corners are taken only while the sequencer is idle. The third corner starts
// the triangle work: the deltas, the multiply steps through the shared 32x32
// multiplier, a drain of the accumulators, divider setup, the six parallel
// bit-serial dividers and the load of the output register. A zero determinant
// skips the dividers.
// Reset (arst_n low) clears the corner count, sequencer and output valid.
// A stalled basis output holds the result; the next triangle is still taken
// and worked, then waits at the output load until the held item leaves.
module triangle_tangent_basis #(
	parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEF,
	parameter int FRAC_BITS  = ttb_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ttb_in_if.sink    corner,
	ttb_out_if.source basis
);
	import ttb_pkg::*;

	cmd_t  cmd;   // sequencer commands
	stat_t stat;  // datapath status

	// sequence the corner count, multiply steps and divide steps
	ttb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// hold corners, accumulate products, divide and saturate
	ttb_dp #(
		.INDEX_BITS (INDEX_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.corner (corner),
		.basis  (basis),
		.cmd    (cmd),
		.stat   (stat)
	);
endmodule

>>> sv/ttb_checker.sv
// Port-level checks of the triangle tangent basis unit, bound to its top level.
// Depends on ttb_pkg and triangle_tangent_basis.
module ttb_checker #(
	parameter int INDEX_BITS = ttb_pkg::INDEX_BITS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    corner_valid,
	input logic                    corner_ready,
	input logic                    basis_valid,
	input logic                    basis_ready,
	input logic [INDEX_BITS-1:0]   corner_index,
	input ttb_pkg::coord_t         tangent_x,
	input ttb_pkg::coord_t         tangent_y,
	input ttb_pkg::coord_t         tangent_z,
	input ttb_pkg::coord_t         binormal_x,
	input ttb_pkg::coord_t         binormal_y,
	input ttb_pkg::coord_t         binormal_z,
	input logic                    degenerate,
	input logic                    clipped
);
	import ttb_pkg::*;

	localparam coord_t SAT_HI = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t SAT_LO = {1'b1, {(COORD_W-1){1'b0}}};

	logic [1:0] seen_q;
	logic       take;

	assign take = corner_valid && corner_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  seen_q <= 2'd0;
		else if (take) seen_q <= (seen_q == 2'd2) ? 2'd0 : seen_q + 2'd1;
	end

	// a stalled result stays valid with corner_index, tangent_x, binormal_z and clipped held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid && !basis_ready |=> basis_valid && $stable(corner_index)
			&& $stable(tangent_x) && $stable(binormal_z) && $stable(clipped))
		else $error("basis changed while stalled");

	// a third corner stops intake
	a_third: assert property (@(posedge clk) disable iff (!arst_n)
		take && seen_q == 2'd2 |=> !corner_ready)
		else $error("corner taken during triangle work");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(basis_valid) |-> !$past(corner_ready))
		else $error("result appeared while idle");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid && degenerate |-> !clipped && tangent_x == '0 && tangent_y == '0
			&& tangent_z == '0 && binormal_x == '0 && binormal_y == '0
			&& binormal_z == '0)
		else $error("degenerate result not zero");

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid && clipped |-> tangent_x == SAT_HI || tangent_x == SAT_LO
			|| tangent_y == SAT_HI || tangent_y == SAT_LO || tangent_z == SAT_HI
			|| tangent_z == SAT_LO || binormal_x == SAT_HI || binormal_x == SAT_LO
			|| binormal_y == SAT_HI || binormal_y == SAT_LO
			|| binormal_z == SAT_HI || binormal_z == SAT_LO)
		else $error("clipped set without a saturated component");
endmodule

bind triangle_tangent_basis ttb_checker #(.INDEX_BITS(INDEX_BITS)) u_ttb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.corner_valid (corner.valid),
	.corner_ready (corner.ready),
	.basis_valid  (basis.valid),
	.basis_ready  (basis.ready),
	.corner_index (basis.corner_index),
	.tangent_x    (basis.tangent_x),
	.tangent_y    (basis.tangent_y),
	.tangent_z    (basis.tangent_z),
	.binormal_x   (basis.binormal_x),
	.binormal_y   (basis.binormal_y),
	.binormal_z   (basis.binormal_z),
	.degenerate   (basis.degenerate),
	.clipped      (basis.clipped)
);
